>>> rtl/core/msb_first_value_packer_unit_assert.svh
// Assertion macros for the MSB-first value packer.
`ifndef MSB_FIRST_VALUE_PACKER_UNIT_ASSERT_SVH
`define MSB_FIRST_VALUE_PACKER_UNIT_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define MFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define MFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mfp_pkg.sv
// Shared constants and result type of the MSB-first value packer.
package mfp_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned IndexBits = 16;
  localparam int unsigned WidthBits = 6;
  localparam int unsigned FillBits  = 5;

  localparam logic [IndexBits-1:0] IndexMax = '1;

  localparam logic StatusData     = 1'b0;
  localparam logic StatusTooWide  = 1'b1;

  typedef struct packed {
    logic [WordBits-1:0]  word;
    logic                 status;
    logic [IndexBits-1:0] idx;
    logic                 last;
  } res_t;

endpackage

>>> rtl/core/msb_first_value_packer_unit.sv
// MSB-first packer of variable-width values into 32-bit words.
// Results are registered: a result appears on the output in the cycle after its item is accepted.
// One item per cycle while the output is not stalled; an item that gives two words
// holds the input while the two-entry result buffer drains.
// Reset (asynchronous, active low) clears the width register, the packing state
// and the discard flag, and empties the result buffer (its entries are not reset).
`include "msb_first_value_packer_unit_assert.svh"

module msb_first_value_packer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel: value_width.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mfp_pkg::WidthBits-1:0]       cfg_data_i,
  // Input items.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mfp_pkg::WordBits-1:0]        s_axis_tdata_i,   // [31:0] value
  input  logic                                s_axis_tlast_i,   // last_value
  // Result items.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [47:0]                         m_axis_tdata_o,   // [31:0] packed_word,
                                                                // [47:32] bad_index
  output logic                                m_axis_tuser_o,   // status
  output logic                                m_axis_tlast_o    // last_word
);
  import mfp_pkg::*;

  logic [WidthBits-1:0] width_q;
  logic [WordBits-1:0]  partial_q, partial_d;
  logic [FillBits-1:0]  fill_q, fill_d;
  logic [IndexBits-1:0] count_q, count_d;
  logic                 disc_q, disc_d;

  res_t                 slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]           cnt_q, cnt_d;

  logic                 in_acc, out_pop;
  logic [WordBits-1:0]  v;
  logic                 bad;
  logic [WidthBits-1:0] space, rest;
  logic                 fits;
  logic [WordBits-1:0]  part_new, word_full;
  logic [FillBits-1:0]  fill_new;
  res_t                 r0, r1;
  logic [1:0]           n_res;

  assign cfg_ready_o     = 1'b1;
  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;
  // Only take an item when the buffer is empty by the end of this cycle.
  assign s_axis_tready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {slot0_q.idx, slot0_q.word};
  assign m_axis_tuser_o  = slot0_q.status;
  assign m_axis_tlast_o  = slot0_q.last;

  assign v = s_axis_tdata_i;

  always_comb begin
    if ((width_q == '0) || (width_q > WidthBits'(WordBits))) begin
      bad = 1'b1;
    end else if (width_q < WidthBits'(WordBits)) begin
      bad = (v >> width_q) != '0;
    end else begin
      bad = 1'b0;
    end
  end

  always_comb begin
    space     = WidthBits'(WordBits) - {1'b0, fill_q};
    fits      = width_q < space;
    rest      = width_q - space;
    word_full = partial_q | (v >> rest);
    if (fits) begin
      part_new = partial_q | (v << (space - width_q));
      fill_new = fill_q + width_q[FillBits-1:0];
    end else begin
      // A shift by the full word width clears the remainder when rest is zero.
      part_new = v << (WidthBits'(WordBits) - rest);
      fill_new = rest[FillBits-1:0];
    end
  end

  always_comb begin
    r0    = '{word: '0, status: StatusData, idx: '0, last: 1'b0};
    r1    = r0;
    n_res = 2'd0;
    if (disc_q) begin
      n_res = 2'd0;
    end else if (bad) begin
      r0    = '{word: '0, status: StatusTooWide, idx: count_q, last: 1'b1};
      n_res = 2'd1;
    end else if (!fits) begin
      r0.word = word_full;
      n_res   = 2'd1;
      if (s_axis_tlast_i) begin
        if (fill_new != '0) begin
          r1.word = part_new;
          r1.last = 1'b1;
          n_res   = 2'd2;
        end else begin
          r0.last = 1'b1;
        end
      end
    end else if (s_axis_tlast_i) begin
      r0.word = part_new;
      r0.last = 1'b1;
      n_res   = 2'd1;
    end
  end

  always_comb begin
    partial_d = partial_q;
    fill_d    = fill_q;
    count_d   = count_q;
    disc_d    = disc_q;
    if (in_acc) begin
      if (disc_q) begin
        if (s_axis_tlast_i) begin
          disc_d    = 1'b0;
          partial_d = '0;
          fill_d    = '0;
          count_d   = '0;
        end
      end else if (bad || s_axis_tlast_i) begin
        disc_d    = bad && !s_axis_tlast_i;
        partial_d = '0;
        fill_d    = '0;
        count_d   = '0;
      end else begin
        partial_d = part_new;
        fill_d    = fill_new;
        if (count_q != IndexMax) begin
          count_d = count_q + IndexBits'(1);
        end
      end
    end
  end

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    if (in_acc) begin
      slot0_d = r0;
      slot1_d = r1;
      cnt_d   = n_res;
    end else if (out_pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= '0;
      partial_q <= '0;
      fill_q    <= '0;
      count_q   <= '0;
      disc_q    <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        width_q <= cfg_data_i;
      end
      partial_q <= partial_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
      disc_q    <= disc_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  `MFP_ASSERT_NOW(a_buf_bound, 1'b1, cnt_q != 2'd3, "result buffer over capacity")
  `MFP_ASSERT_NOW(a_acc_room, in_acc, (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_pop), "item accepted without buffer room")
  `MFP_ASSERT_NEXT(a_disc_quiet, in_acc && disc_q, cnt_q == 2'd0, "discarded item produced a result")
  `MFP_ASSERT_NOW(a_err_form, m_axis_tvalid_o && m_axis_tuser_o, (m_axis_tdata_o[31:0] == '0) && m_axis_tlast_o, "malformed error result")

endmodule
